@@ design/iir_tdf2_pkg.sv @@
package iir_tdf2_pkg;

    localparam int COEF_W     = 18;
    localparam int DELAY_W    = 48;
    localparam int MAX_DELAYS = 3;
    localparam int NUM_REGS   = 7;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef t_coef [NUM_REGS-1:0]      t_coef_bank;
    typedef logic [CFG_IDX_W-1:0]      t_reg_idx;
    typedef logic signed [DELAY_W-1:0] t_delay;

    // register map
    localparam t_reg_idx REG_B0 = 3'd0;
    localparam t_reg_idx REG_B1 = 3'd1;
    localparam t_reg_idx REG_B2 = 3'd2;
    localparam t_reg_idx REG_B3 = 3'd3;
    localparam t_reg_idx REG_A1 = 3'd4;
    localparam t_reg_idx REG_A2 = 3'd5;
    localparam t_reg_idx REG_A3 = 3'd6;

    // item kinds
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // b0 = 1.0 in Q4.14
    localparam t_coef COEF_B0_RESET = 18'sd16384;

endpackage

@@ design/iir_tdf2_in_if.sv @@
interface iir_tdf2_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic [1:0]                     delay_index;

    modport source (output valid, operation, value, delay_index, input ready);
    modport sink   (input valid, operation, value, delay_index, output ready);
endinterface

@@ design/iir_tdf2_out_if.sv @@
interface iir_tdf2_out_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
    logic                           saturated;

    modport source (output valid, filtered_sample, saturated, input ready);
    modport sink   (input valid, filtered_sample, saturated, output ready);
endinterface

@@ design/iir_tdf2_cfg_if.sv @@
interface iir_tdf2_cfg_if
    import iir_tdf2_pkg::*;
();
    logic     valid;
    logic     ready;
    t_reg_idx index;
    t_coef    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/iir_tdf2_regs.sv @@
module iir_tdf2_regs
    import iir_tdf2_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    iir_tdf2_cfg_if.sink i_cfg,
    output t_coef_bank   o_coefs
);

    t_coef_bank r_coefs;

    // always accepts; index 7 falls through
    assign i_cfg.ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs         <= '0;
            r_coefs[REG_B0] <= COEF_B0_RESET;
        end else begin
            for (int k = 0; k < NUM_REGS; k++) begin
                if (i_cfg.valid && i_cfg.index == CFG_IDX_W'(k)) begin
                    r_coefs[k] <= i_cfg.data;
                end
            end
        end
    end

endmodule

@@ design/iir_filter_transposed_df2_unit.sv @@
// Channel   Dir  Handshake      Payload
// i_smp     in   valid/ready    operation, value, delay_index
// o_res     out  valid/ready    filtered_sample, saturated
// i_cfg     in   valid/ready    index, data (coefficient registers 0..6)
//
// A sample transfer drops ready until the sequencer is back in idle, so a new sample
// is taken only once the last is through: one shared 18 x SAMPLE_WIDTH multiplier
// forms all 2*NUM_COEFFS-1 products in turn. A load transfer writes its delay
// element at the transfer edge and ready stays high. Reset is synchronous, active low:
// delays cleared, b0 = 1.0. The result sits in an output register; only a new result
// finding it still full stalls the sequencer, for as long as the register stays blocked.
module iir_filter_transposed_df2_unit
    import iir_tdf2_pkg::*;
#(
    parameter int NUM_COEFFS     = 4,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    iir_tdf2_in_if.sink    i_smp,
    iir_tdf2_out_if.source o_res,
    iir_tdf2_cfg_if.sink   i_cfg
);

    localparam int NDELAY  = NUM_COEFFS - 1;
    localparam int PROD_W  = COEF_W + SAMPLE_WIDTH;
    localparam int LD_W    = SAMPLE_WIDTH + COEF_FRAC_BITS;
    localparam int MAX_PD  = (PROD_W > DELAY_W) ? PROD_W : DELAY_W;
    localparam int MAX_ALL = (LD_W > MAX_PD) ? LD_W : MAX_PD;
    // room for three terms of the delay update
    localparam int ACC_W   = MAX_ALL + 2;

    localparam logic [1:0] LAST_J = 2'(NUM_COEFFS - 1);

    localparam logic signed [ACC_W-1:0] D_MAX =
        {{(ACC_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] D_MIN =
        {{(ACC_W-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] S_MAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_MIN =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    // round half up before the floor shift
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transfer
    localparam logic [2:0] ST_MB0  = 3'd1;  // b0*x
    localparam logic [2:0] ST_Y    = 3'd2;  // y from b0*x + d0; b1*x
    localparam logic [2:0] ST_AJ   = 3'd3;  // b[j]*x + d[j]; a[j]*y
    localparam logic [2:0] ST_DJ   = 3'd4;  // d[j-1] update; b[j+1]*x
    localparam logic [2:0] ST_WAIT = 3'd5;  // output register still full

    function automatic t_delay f_sat_delay(input logic signed [ACC_W-1:0] v);
        if (v > D_MAX) begin
            return D_MAX[DELAY_W-1:0];
        end else if (v < D_MIN) begin
            return D_MIN[DELAY_W-1:0];
        end
        return v[DELAY_W-1:0];
    endfunction

    t_coef_bank coefs;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_j;

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                           r_sat;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    t_delay                         r_d [MAX_DELAYS];

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_sat;

    logic                           in_xfer;
    logic                           ld_en;
    logic                           out_free;
    logic                           result_load;
    t_reg_idx                       coef_sel;
    t_coef                          mul_coef;
    logic signed [SAMPLE_WIDTH-1:0] mul_opd;
    t_delay                         d_next;
    t_delay                         ld_sat;
    t_delay                         upd_sat;
    logic signed [ACC_W-1:0]        y_acc;
    logic signed [ACC_W-1:0]        y_shift;
    logic signed [SAMPLE_WIDTH-1:0] y_val;
    logic                           y_clip;

    iir_tdf2_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_coefs (coefs)
    );

    assign i_smp.ready = (r_state == ST_IDLE);
    assign in_xfer     = i_smp.valid && i_smp.ready;
    assign ld_en       = in_xfer && (i_smp.operation == OP_LOAD);
    assign out_free    = !r_out_valid || o_res.ready;
    assign result_load = ((r_state == ST_DJ && r_j == LAST_J) || r_state == ST_WAIT)
                         && out_free;

    // ---- shared multiplier: operand selection per step ----
    always_comb begin
        case (r_state)
            ST_MB0:  coef_sel = REG_B0;
            ST_Y:    coef_sel = REG_B1;
            ST_AJ:   coef_sel = REG_B3 + CFG_IDX_W'(r_j);  // a[j]
            default: coef_sel = REG_B1 + CFG_IDX_W'(r_j);  // b[j+1]
        endcase
    end

    assign mul_coef = coefs[coef_sel];
    assign mul_opd  = (r_state == ST_AJ) ? r_y : r_x;

    // d[j]; the top delay reads zero (unused entries are never written)
    always_comb begin
        case (r_j)
            2'd1:    d_next = r_d[1];
            2'd2:    d_next = r_d[2];
            default: d_next = '0;
        endcase
    end

    // ---- output: round, floor shift, clip ----
    assign y_acc   = ACC_W'(r_prod) + ACC_W'(r_d[0]) + HALF;
    assign y_shift = y_acc >>> COEF_FRAC_BITS;
    always_comb begin
        y_clip = 1'b1;
        if (y_shift > S_MAX) begin
            y_val = Y_MAX;
        end else if (y_shift < S_MIN) begin
            y_val = Y_MIN;
        end else begin
            y_val  = y_shift[SAMPLE_WIDTH-1:0];
            y_clip = 1'b0;
        end
    end

    // delay update: (b[j]*x + d[j]) - a[j]*y
    assign upd_sat = f_sat_delay(r_acc - ACC_W'(r_prod));
    // load item: value in sample units scaled up to the delay format
    assign ld_sat  = f_sat_delay(ACC_W'($signed(i_smp.value)) <<< COEF_FRAC_BITS);

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_smp.operation == OP_FILTER) begin
                    n_state = ST_MB0;
                end
            end
            ST_MB0: n_state = ST_Y;
            ST_Y:   n_state = ST_AJ;
            ST_AJ:  n_state = ST_DJ;
            ST_DJ: begin
                if (r_j != LAST_J) begin
                    n_state = ST_AJ;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_j         <= 2'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_Y) begin
                r_j <= 2'd1;
            end else if (r_state == ST_DJ && r_j != LAST_J) begin
                r_j <= r_j + 2'd1;
            end
            if (result_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_coef) * PROD_W'(mul_opd);
        if (in_xfer) begin
            r_x <= i_smp.value;
        end
        if (r_state == ST_Y) begin
            r_y   <= y_val;
            r_sat <= y_clip;
        end
        if (r_state == ST_AJ) begin
            r_acc <= ACC_W'(r_prod) + ACC_W'(d_next);
        end
        if (result_load) begin
            r_out_sample <= r_y;
            r_out_sat    <= r_sat;
        end
    end

    // delay line; an out-of-range load index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_DELAYS; k++) begin
                r_d[k] <= '0;
            end
        end else begin
            for (int k = 0; k < MAX_DELAYS; k++) begin
                if (ld_en && i_smp.delay_index == 2'(k) && k < NDELAY) begin
                    r_d[k] <= ld_sat;
                end else if (r_state == ST_DJ && r_j == 2'(k + 1)) begin
                    r_d[k] <= upd_sat;
                end
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.filtered_sample = r_out_sample;
    assign o_res.saturated       = r_out_sat;

    // ---- checks ----
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_smp.operation == OP_FILTER) |=> !i_smp.ready)
        else $error("block ready right after a sample transfer");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_en |=> (r_state == ST_IDLE))
        else $error("load item started the sequencer");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AJ || r_state == ST_DJ) |-> (r_j != 2'd0 && r_j <= LAST_J))
        else $error("tap counter out of range");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DJ || $past(r_state) == ST_WAIT))
        else $error("result appeared outside the final step");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
            (r_out_sample == Y_MAX || r_out_sample == Y_MIN))
        else $error("clip flag without a rail value");

endmodule
